[rtl/arp_cache_and_receive_assert.svh]
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_AND_RECEIVE_ASSERT_SVH
`define ARP_CACHE_AND_RECEIVE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds on every clock edge outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never comes true outside reset.
`define ARPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARPC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

[rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// ARP cache package
// Shared constants, status codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int DefTableDepth = 16;
  localparam int QueueDepth    = 2;

  localparam int IpW  = 32;
  localparam int MacW = 48;

  localparam logic [15:0] MinLen     = 16'd28;
  localparam logic [15:0] HwEthernet = 16'h0001;
  localparam logic [15:0] ProtoIpv4  = 16'h0800;
  localparam logic [7:0]  HwAddrLen  = 8'd6;
  localparam logic [7:0]  IpAddrLen  = 8'd4;
  localparam logic [15:0] OpRequest  = 16'h0001;

  localparam logic [IpW-1:0]  IpBroadcast  = '1;
  localparam logic [MacW-1:0] MacBroadcast = '1;

  // Item kinds on the op input
  localparam logic OpReceive = 1'b0;
  localparam logic OpLookup  = 1'b1;

  typedef enum logic [2:0] {
    StLearned = 3'd0,
    StShort   = 3'd1,
    StBadHdr  = 3'd2,
    StHit     = 3'd3,
    StMiss    = 3'd4,
    StBcast   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KindLookup,
    KindLearn,
    KindShort,
    KindBadHdr
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic            reply;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } cmd_t;

endpackage

[rtl/arpc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/arpc_front.sv]
// ----------------------------------------------------------------------------
// ARP cache front end
// Hold own_ip, accept items and classify them into commands.
// ----------------------------------------------------------------------------
module arpc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  own_ip_we_i,
  input  logic [31:0]           own_ip_i,
  input  logic                  start,
  output logic                  busy,
  input  logic                  op_i,
  input  logic [15:0]           packet_length_i,
  input  logic [15:0]           hw_type_i,
  input  logic [15:0]           prot_type_i,
  input  logic [7:0]            hw_len_i,
  input  logic [7:0]            prot_len_i,
  input  logic [15:0]           arp_opcode_i,
  input  logic [47:0]           src_mac_i,
  input  logic [31:0]           src_ip_i,
  input  logic [31:0]           dst_ip_i,
  input  logic [31:0]           query_ip_i,
  input  logic                  full_i,
  output logic                  push_o,
  output arpc_pkg::cmd_t        cmd_o
);
  import arpc_pkg::*;

  logic [31:0] own_ip_q;
  logic        hdr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (own_ip_we_i) begin
      own_ip_q <= own_ip_i;
    end
  end

  assign hdr_ok = (hw_type_i == HwEthernet) && (prot_type_i == ProtoIpv4) &&
                  (hw_len_i == HwAddrLen) && (prot_len_i == IpAddrLen);

  always_comb begin
    cmd_o = '0;
    if (op_i == OpLookup) begin
      cmd_o.kind = KindLookup;
      cmd_o.ip   = query_ip_i;
    end else if (packet_length_i < MinLen) begin
      cmd_o.kind = KindShort;
    end else if (!hdr_ok) begin
      cmd_o.kind = KindBadHdr;
    end else begin
      cmd_o.kind  = KindLearn;
      cmd_o.ip    = src_ip_i;
      cmd_o.mac   = src_mac_i;
      cmd_o.reply = (arp_opcode_i == OpRequest) && (dst_ip_i == own_ip_q);
    end
  end

  assign busy   = full_i;
  assign push_o = start && !full_i;

endmodule

[rtl/arpc_fifo.sv]
// ----------------------------------------------------------------------------
// ARP command queue
// Short queue that decouples classification from the table scan.
// ----------------------------------------------------------------------------
module arpc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  arpc_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output arpc_pkg::cmd_t cmd_o
);
  import arpc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/arpc_back.sv]
// ----------------------------------------------------------------------------
// ARP cache back end
// Scan the table for each command, learn senders and issue results.
// ----------------------------------------------------------------------------
`include "arp_cache_and_receive_assert.svh"

module arpc_back #(
  parameter int TableDepth = arpc_pkg::DefTableDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  arpc_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           done_o,
  output logic [2:0]     status_o,
  output logic           send_reply_o,
  output logic [31:0]    reply_ip_o,
  output logic [47:0]    reply_mac_o,
  output logic [47:0]    found_mac_o
);
  import arpc_pkg::*;

  localparam int IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int EntW = IpW + MacW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableDepth - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  state_e                state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [IdxW-1:0]       rd_idx_q, rd_idx_d;
  logic                  issue_done_q, issue_done_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                  hit_q, hit_d;
  logic [IdxW-1:0]       hit_idx_q, hit_idx_d;
  logic [MacW-1:0]       hit_mac_q, hit_mac_d;
  logic                  free_q, free_d;
  logic [IdxW-1:0]       free_idx_q, free_idx_d;
  logic [TableDepth-1:0] valid_q, valid_d;
  logic                  done_q, done_d;
  status_e               status_q, status_d;
  logic                  send_reply_q, send_reply_d;
  logic [IpW-1:0]        reply_ip_q, reply_ip_d;
  logic [MacW-1:0]       reply_mac_q, reply_mac_d;
  logic [MacW-1:0]       found_mac_q, found_mac_d;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  logic [EntW-1:0]       ram_rdata;
  logic [IpW-1:0]        ent_ip;
  logic [MacW-1:0]       ent_mac;
  logic                  ent_valid;

  arpc_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({cmd_q.ip, cmd_q.mac}),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign ent_ip    = ram_rdata[EntW-1:MacW];
  assign ent_mac   = ram_rdata[MacW-1:0];
  assign ent_valid = valid_q[cmp_idx_q];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    rd_idx_d     = rd_idx_q;
    issue_done_d = issue_done_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_mac_d    = hit_mac_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    valid_d      = valid_q;
    done_d       = 1'b0;
    status_d     = status_q;
    send_reply_d = send_reply_q;
    reply_ip_d   = reply_ip_q;
    reply_mac_d  = reply_mac_q;
    found_mac_d  = found_mac_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = hit_q ? hit_idx_q : (free_q ? free_idx_q : '0);

    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.kind) inside
            KindShort, KindBadHdr: begin
              // Rejected packets report at once and touch no entry
              done_d       = 1'b1;
              status_d     = (cmd_i.kind == KindShort) ? StShort : StBadHdr;
              send_reply_d = 1'b0;
              reply_ip_d   = '0;
              reply_mac_d  = '0;
              found_mac_d  = '0;
            end
            default: begin
              rd_idx_d     = '0;
              issue_done_d = 1'b0;
              hit_d        = 1'b0;
              free_d       = 1'b0;
              state_d      = StScan;
            end
          endcase
        end
      end

      StScan: begin
        if (!issue_done_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q == LastIdx) begin
            issue_done_d = 1'b1;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (cmp_vld_q) begin
          if (ent_valid && (ent_ip == cmd_q.ip)) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_mac_d = ent_mac;
            state_d   = StFinish;
          end else begin
            if (!ent_valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = cmp_idx_q;
            end
            if (cmp_idx_q == LastIdx) begin
              state_d = StFinish;
            end
          end
        end
      end

      StFinish: begin
        state_d = StIdle;
        done_d  = 1'b1;
        if (cmd_q.kind == KindLearn) begin
          // Update the match, else take the first free slot, else slot zero
          ram_we             = 1'b1;
          valid_d[ram_waddr] = 1'b1;
          status_d           = StLearned;
          send_reply_d       = cmd_q.reply;
          reply_ip_d         = cmd_q.reply ? cmd_q.ip : '0;
          reply_mac_d        = cmd_q.reply ? cmd_q.mac : '0;
          found_mac_d        = '0;
        end else begin
          send_reply_d = 1'b0;
          reply_ip_d   = '0;
          reply_mac_d  = '0;
          if (hit_q) begin
            status_d    = StHit;
            found_mac_d = hit_mac_q;
          end else if (cmd_q.ip == IpBroadcast) begin
            status_d    = StBcast;
            found_mac_d = MacBroadcast;
          end else begin
            status_d    = StMiss;
            found_mac_d = '0;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cmd_q        <= '0;
      rd_idx_q     <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      hit_mac_q    <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      done_q       <= 1'b0;
      status_q     <= StLearned;
      send_reply_q <= 1'b0;
      reply_ip_q   <= '0;
      reply_mac_q  <= '0;
      found_mac_q  <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      rd_idx_q     <= rd_idx_d;
      issue_done_q <= issue_done_d;
      cmp_vld_q    <= cmp_vld_d;
      cmp_idx_q    <= cmp_idx_d;
      hit_q        <= hit_d;
      hit_idx_q    <= hit_idx_d;
      hit_mac_q    <= hit_mac_d;
      free_q       <= free_d;
      free_idx_q   <= free_idx_d;
      valid_q      <= valid_d;
      done_q       <= done_d;
      status_q     <= status_d;
      send_reply_q <= send_reply_d;
      reply_ip_q   <= reply_ip_d;
      reply_mac_q  <= reply_mac_d;
      found_mac_q  <= found_mac_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign send_reply_o = send_reply_q;
  assign reply_ip_o   = reply_ip_q;
  assign reply_mac_o  = reply_mac_q;
  assign found_mac_o  = found_mac_q;

  `ARPC_ASSERT(a_finish_then_done, clk_i, rst_ni, (state_q == StFinish) |=> done_q, "finish without result")
  `ARPC_ASSERT(a_we_only_learn, clk_i, rst_ni, ram_we |-> (cmd_q.kind == KindLearn), "table write outside learn")
  `ARPC_ASSERT(a_scan_kind, clk_i, rst_ni, (state_q == StScan) |-> (cmd_q.kind == KindLookup || cmd_q.kind == KindLearn), "scan of rejected command")
  `ARPC_ASSERT(a_reply_learned, clk_i, rst_ni, (done_q && send_reply_q) |-> (status_q == StLearned), "reply without learn")
  `ARPC_ASSERT_NEVER(a_no_pop_busy, clk_i, rst_ni, pop_o && (state_q != StIdle), "pop while busy")

endmodule

[rtl/arp_cache_and_receive.sv]
// ----------------------------------------------------------------------------
// ARP cache and receive path
// IPv4-to-MAC cache with ARP packet checking, learning and lookups.
// ----------------------------------------------------------------------------
// Drive an item with start high; it transfers at a rising edge where busy is
// low. Each item yields one result, shown for a single cycle with done_o high;
// the receiver must take it then, it cannot stall the block. A short or
// malformed packet is popped from the queue and reported without a table
// scan. A lookup or a learn walks the table one entry per cycle through the
// single read port of the table RAM, which has registered read data, and
// stops early when the address is found; a finish state then writes a
// learned entry or reports the lookup. A two-entry command queue sits
// between classification and the scan; busy rises only while it is full.
// Valid bits clear at reset, so no clearing pass is needed. Write own_ip
// only while no item is in flight.
// ----------------------------------------------------------------------------
module arp_cache_and_receive #(
  parameter int TABLE_DEPTH = arpc_pkg::DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        own_ip_we_i,
  input  logic [31:0] own_ip_i,
  // Command channel
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [15:0] packet_length_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] prot_type_i,
  input  logic [7:0]  hw_len_i,
  input  logic [7:0]  prot_len_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [47:0] src_mac_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [31:0] query_ip_i,
  // Result channel
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        send_reply_o,
  output logic [31:0] reply_ip_o,
  output logic [47:0] reply_mac_o,
  output logic [47:0] found_mac_o
);
  import arpc_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, full, pop, empty;

  // Classify each transfer and keep own_ip
  arpc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .own_ip_we_i     (own_ip_we_i),
    .own_ip_i        (own_ip_i),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .packet_length_i (packet_length_i),
    .hw_type_i       (hw_type_i),
    .prot_type_i     (prot_type_i),
    .hw_len_i        (hw_len_i),
    .prot_len_i      (prot_len_i),
    .arp_opcode_i    (arp_opcode_i),
    .src_mac_i       (src_mac_i),
    .src_ip_i        (src_ip_i),
    .dst_ip_i        (dst_ip_i),
    .query_ip_i      (query_ip_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  // Hold classified commands until the back end is free
  arpc_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (queue_cmd)
  );

  // Scan, learn and report
  arpc_back #(
    .TableDepth (TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .cmd_i        (queue_cmd),
    .pop_o        (pop),
    .done_o       (done_o),
    .status_o     (status_o),
    .send_reply_o (send_reply_o),
    .reply_ip_o   (reply_ip_o),
    .reply_mac_o  (reply_mac_o),
    .found_mac_o  (found_mac_o)
  );

endmodule
